/* design/vgp_pkg.sv */
package vgp_pkg;

  typedef struct packed {
    logic       load;
    logic       hdr;
    logic       eol;
    logic       smp;
    logic [1:0] hkind;
  } ctl_t;

  localparam logic [1:0] KIND_LOCUS  = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_EOL    = 2'd2;
  localparam logic [1:0] KIND_BADPOS = 2'd3;

  localparam logic [2:0] PH_CHROM     = 3'd0;
  localparam logic [2:0] PH_POS       = 3'd1;
  localparam logic [2:0] PH_ID        = 3'd2;
  localparam logic [2:0] PH_REF_FIRST = 3'd3;
  localparam logic [2:0] PH_REF_REST  = 3'd4;
  localparam logic [2:0] PH_ALT       = 3'd5;
  localparam logic [2:0] PH_SKIP      = 3'd6;
  localparam logic [2:0] PH_SAMPLE    = 3'd7;

  localparam logic [1:0] GS_AWAIT  = 2'd0;
  localparam logic [1:0] GS_DIGITS = 2'd1;
  localparam logic [1:0] GS_SKIP   = 2'd2;

  localparam logic [3:0]  UNKNOWN_CODE = 4'hf;
  localparam logic [15:0] GT_SAT       = 16'hffff;
  localparam logic [7:0]  CH_TAB       = 8'h09;
  localparam logic [7:0]  CH_NL        = 8'h0a;
  localparam logic [7:0]  CH_COMMA     = 8'h2c;
  localparam logic [7:0]  CH_ZERO      = 8'h30;
  localparam logic [7:0]  CH_NINE      = 8'h39;
  localparam logic [2:0]  SKIP_FIELDS  = 3'd4;

  function automatic logic [3:0] nuc_code(input logic [7:0] c);
    logic [7:0] u;
    logic [3:0] r;
    u = c & 8'hdf;
    case (u)
      8'h41:   r = 4'h1;
      8'h43:   r = 4'h2;
      8'h47:   r = 4'h4;
      8'h54:   r = 4'h8;
      8'h52:   r = 4'h5;
      8'h59:   r = 4'ha;
      8'h53:   r = 4'h6;
      8'h57:   r = 4'h9;
      8'h4b:   r = 4'hc;
      8'h4d:   r = 4'h3;
      8'h42:   r = 4'he;
      8'h44:   r = 4'hd;
      8'h48:   r = 4'hb;
      8'h56:   r = 4'h7;
      default: r = UNKNOWN_CODE;
    endcase
    if ((c & 8'he0) != 8'h40 && (c & 8'he0) != 8'h60) r = UNKNOWN_CODE;
    return r;
  endfunction

endpackage

/* design/vgp_ram.sv */
module vgp_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/vgp_fifo.sv */
module vgp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(DEPTH)) else $error("queue count beyond depth");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> (!push_i || pop_i)) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");

endmodule

/* design/vgp_front.sv */
module vgp_front
  import vgp_pkg::*;
#(
  parameter int MAX_COLUMNS = 4096,
  parameter int MAX_ALTS    = 8,
  parameter int NODE_BITS   = 24,
  parameter int FIRST_SAMPLE_COLUMN = 9
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic                                mode_i,
  input  logic [7:0]                          text_byte_i,
  input  logic [11:0]                         map_column_i,
  input  logic signed [NODE_BITS:0]           map_node_i,
  output logic                                push_o,
  output ctl_t                                ctl_o,
  output logic [$clog2(MAX_COLUMNS):0]        col_o,
  output logic [NODE_BITS:0]                  node_o,
  output logic [3:0]                          allele_o,
  output logic [31:0]                         pos_o,
  output logic [3:0]                          ref_o
);

  localparam int CW  = $clog2(MAX_COLUMNS) + 1;
  localparam int AIW = (MAX_ALTS > 1) ? $clog2(MAX_ALTS) : 1;
  localparam int ACW = $clog2(MAX_ALTS + 1);

  logic [2:0]     phase_q, phase_d;
  logic [31:0]    pos_q, pos_d;
  logic [3:0]     ref_q, ref_d;
  logic [3:0]     alt_q [MAX_ALTS];
  logic [ACW-1:0] altc_q, altc_d;
  logic [2:0]     skip_q, skip_d;
  logic [15:0]    gacc_q, gacc_d;
  logic [1:0]     gst_q, gst_d;
  logic [CW-1:0]  colc_q, colc_d;

  logic        is_digit, is_tab, is_nl, alt_we, col_ok;
  logic [3:0]  digit, byte_code;
  logic [35:0] pos_mul;
  logic [19:0] g_mul;
  logic [15:0] g_fin, g_m1;
  logic        g_nz, g_over;
  logic [3:0]  fin_allele;
  logic [31:0] load_col;

  assign is_digit  = (text_byte_i >= CH_ZERO) && (text_byte_i <= CH_NINE);
  assign is_tab    = (text_byte_i == CH_TAB);
  assign is_nl     = (text_byte_i == CH_NL);
  assign digit     = 4'(text_byte_i - CH_ZERO);
  assign byte_code = nuc_code(text_byte_i);
  assign pos_mul   = {pos_q, 3'b000} + {3'b000, pos_q, 1'b0} + 36'(digit);
  assign g_mul     = {1'b0, gacc_q, 3'b000} + {3'b000, gacc_q, 1'b0} + 20'(digit);
  assign g_fin     = (gst_q == GS_AWAIT) ? GT_SAT : gacc_q;
  assign g_nz      = (g_fin != '0);
  assign g_over    = (g_fin > 16'(altc_q));
  assign g_m1      = g_fin - 16'd1;
  assign fin_allele = g_over ? UNKNOWN_CODE : alt_q[g_m1[AIW-1:0]];
  assign col_ok    = (32'(colc_q) < 32'(MAX_COLUMNS));
  assign load_col  = 32'(map_column_i);

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    ref_d   = ref_q;
    altc_d  = altc_q;
    skip_d  = skip_q;
    gacc_d  = gacc_q;
    gst_d   = gst_q;
    colc_d  = colc_q;
    alt_we  = 1'b0;
    push_o  = 1'b0;
    ctl_o   = '0;
    col_o   = colc_q;
    node_o  = map_node_i;
    allele_o = fin_allele;
    pos_o   = pos_q;
    ref_o   = ref_q;
    if (accept_i) begin
      if (mode_i) begin
        if (load_col < 32'(MAX_COLUMNS)) begin
          push_o     = 1'b1;
          ctl_o.load = 1'b1;
          col_o      = load_col[CW-1:0];
        end
      end else if (is_nl) begin
        push_o    = 1'b1;
        ctl_o.eol = 1'b1;
        ctl_o.smp = (phase_q == PH_SAMPLE) && g_nz && col_ok;
        phase_d = PH_CHROM;
        pos_d   = '0;
        ref_d   = '0;
        altc_d  = '0;
        skip_d  = '0;
        gacc_d  = '0;
        gst_d   = GS_AWAIT;
        colc_d  = CW'(FIRST_SAMPLE_COLUMN);
      end else begin
        unique case (phase_q)
          PH_CHROM: begin
            if (is_tab) phase_d = PH_POS;
          end
          PH_POS: begin
            if (is_tab) phase_d = PH_ID;
            else if (is_digit) pos_d = (pos_mul[35:32] != '0) ? '1 : pos_mul[31:0];
          end
          PH_ID: begin
            if (is_tab) begin
              phase_d = PH_REF_FIRST;
              ref_d   = UNKNOWN_CODE;
            end
          end
          PH_REF_FIRST, PH_REF_REST: begin
            if (is_tab) begin
              push_o      = 1'b1;
              ctl_o.hdr   = 1'b1;
              ctl_o.hkind = (pos_q == '0) ? KIND_BADPOS : KIND_LOCUS;
              phase_d     = PH_ALT;
              altc_d      = '0;
            end else if (phase_q == PH_REF_FIRST) begin
              ref_d   = byte_code;
              phase_d = PH_REF_REST;
            end
          end
          PH_ALT: begin
            if (is_tab) begin
              phase_d = PH_SKIP;
              skip_d  = '0;
            end else if (text_byte_i != CH_COMMA && 32'(altc_q) < 32'(MAX_ALTS)) begin
              alt_we = 1'b1;
              altc_d = altc_q + 1'b1;
            end
          end
          PH_SKIP: begin
            if (is_tab) begin
              skip_d = skip_q + 1'b1;
              if (skip_q + 3'd1 >= SKIP_FIELDS) begin
                phase_d = PH_SAMPLE;
                colc_d  = CW'(FIRST_SAMPLE_COLUMN);
                gacc_d  = '0;
                gst_d   = GS_AWAIT;
              end
            end
          end
          PH_SAMPLE: begin
            if (is_tab) begin
              if (g_nz && col_ok) begin
                push_o    = 1'b1;
                ctl_o.smp = 1'b1;
              end
              if (col_ok) colc_d = colc_q + 1'b1;
              gacc_d = '0;
              gst_d  = GS_AWAIT;
            end else if (gst_q == GS_AWAIT) begin
              if (is_digit) begin
                gacc_d = 16'(digit);
                gst_d  = GS_DIGITS;
              end else begin
                gacc_d = GT_SAT;
                gst_d  = GS_SKIP;
              end
            end else if (gst_q == GS_DIGITS) begin
              if (is_digit) gacc_d = (g_mul[19:16] != '0) ? GT_SAT : g_mul[15:0];
              else gst_d = GS_SKIP;
            end
          end
          default: phase_d = PH_CHROM;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CHROM;
      pos_q   <= '0;
      ref_q   <= '0;
      altc_q  <= '0;
      skip_q  <= '0;
      gacc_q  <= '0;
      gst_q   <= GS_AWAIT;
      colc_q  <= CW'(FIRST_SAMPLE_COLUMN);
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      ref_q   <= ref_d;
      altc_q  <= altc_d;
      skip_q  <= skip_d;
      gacc_q  <= gacc_d;
      gst_q   <= gst_d;
      colc_q  <= colc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (alt_we) begin
      alt_q[altc_q[AIW-1:0]] <= byte_code;
    end
  end

  a_altc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(altc_q) <= 32'(MAX_ALTS)) else $error("alt count beyond limit");
  a_sample_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && ctl_o.smp) |-> (phase_q == PH_SAMPLE && col_ok))
    else $error("sample word outside sample columns");
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> $onehot({ctl_o.load, ctl_o.hdr, ctl_o.eol, ctl_o.smp && !ctl_o.eol}))
    else $error("queue word with no single operation");

endmodule

/* design/vgp_back.sv */
module vgp_back
  import vgp_pkg::*;
#(
  parameter int MAX_COLUMNS = 4096,
  parameter int NODE_BITS   = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  output logic                          pop_o,
  input  ctl_t                          ctl_i,
  input  logic [$clog2(MAX_COLUMNS):0]  col_i,
  input  logic [NODE_BITS:0]            node_i,
  input  logic [3:0]                    allele_i,
  input  logic [31:0]                   pos_i,
  input  logic [3:0]                    ref_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic [31:0]                   position_o,
  output logic [3:0]                    ref_code_o,
  output logic [NODE_BITS-1:0]          node_index_o,
  output logic [3:0]                    allele_code_o,
  output logic                          last_o
);

  localparam int AW = $clog2(MAX_COLUMNS);

  logic                 s1_v_q;
  ctl_t                 s1_ctl_q;
  logic [3:0]           s1_allele_q;
  logic [31:0]          s1_pos_q;
  logic [3:0]           s1_ref_q;
  logic [NODE_BITS:0]   rd_node;
  logic                 emit, two, any, out_free, s1_adv;

  logic                 out_v_q, pend_v_q;
  logic [1:0]           out_kind_q;
  logic [31:0]          out_pos_q, pend_pos_q;
  logic [3:0]           out_ref_q, pend_ref_q;
  logic [NODE_BITS-1:0] out_node_q;
  logic [3:0]           out_allele_q;
  logic                 out_last_q;

  vgp_ram #(
    .WIDTH(NODE_BITS + 1),
    .DEPTH(MAX_COLUMNS)
  ) u_map (
    .clk_i  (clk_i),
    .addr_i (col_i[AW-1:0]),
    .we_i   (pop_o && ctl_i.load),
    .wdata_i(node_i),
    .re_i   (pop_o && ctl_i.smp),
    .rdata_o(rd_node)
  );

  assign emit     = s1_ctl_q.smp && !rd_node[NODE_BITS] && (rd_node != '0);
  assign any      = emit || s1_ctl_q.hdr || s1_ctl_q.eol;
  assign two      = emit && s1_ctl_q.eol;
  assign out_free = !pend_v_q && (!out_v_q || !out_stall_i);
  assign s1_adv   = s1_v_q && (!any || out_free);
  assign pop_o    = !empty_i && (!s1_v_q || s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s1_ctl_q <= '0;
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      if (pop_o) begin
        s1_v_q   <= 1'b1;
        s1_ctl_q <= ctl_i;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (pend_v_q) begin
        if (!out_stall_i) begin
          out_v_q  <= 1'b1;
          pend_v_q <= 1'b0;
        end
      end else if (s1_adv && any) begin
        out_v_q  <= 1'b1;
        pend_v_q <= two;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_allele_q <= allele_i;
      s1_pos_q    <= pos_i;
      s1_ref_q    <= ref_i;
    end
    if (pend_v_q) begin
      if (!out_stall_i) begin
        out_kind_q   <= KIND_EOL;
        out_pos_q    <= pend_pos_q;
        out_ref_q    <= pend_ref_q;
        out_node_q   <= '0;
        out_allele_q <= '0;
        out_last_q   <= 1'b1;
      end
    end else if (s1_adv && any) begin
      out_pos_q  <= s1_pos_q;
      out_ref_q  <= s1_ref_q;
      pend_pos_q <= s1_pos_q;
      pend_ref_q <= s1_ref_q;
      if (emit) begin
        out_kind_q   <= KIND_SAMPLE;
        out_node_q   <= rd_node[NODE_BITS-1:0];
        out_allele_q <= s1_allele_q;
        out_last_q   <= !s1_ctl_q.eol;
      end else begin
        out_kind_q   <= s1_ctl_q.eol ? KIND_EOL : s1_ctl_q.hkind;
        out_node_q   <= '0;
        out_allele_q <= '0;
        out_last_q   <= 1'b1;
      end
    end
  end

  assign out_valid_o   = out_v_q;
  assign kind_o        = out_kind_q;
  assign position_o    = out_pos_q;
  assign ref_code_o    = out_ref_q;
  assign node_index_o  = out_node_q;
  assign allele_code_o = out_allele_q;
  assign last_o        = out_last_q;

  a_pend_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> out_v_q) else $error("pending word without output word");
  a_not_last_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_last_q) |-> pend_v_q) else $error("open item without second word");
  a_pend_is_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> (out_kind_q == KIND_SAMPLE)) else $error("pending word after non-sample");

endmodule

/* design/vcf_genotype_line_parser.sv */
// channel  handshake                 payload
// in       in_valid_i / in_stall_o   mode_i text_byte_i map_column_i map_node_i
// out      out_valid_o / out_stall_i kind_o position_o ref_code_o node_index_o
//                                    allele_code_o last_o
// one word accepted per cycle unless in_stall_o is raised; a result passes
// the queue, the back-end stage that reads the column map and the output
// register; a newline closing a mapped sample gives a sample word, then an
// end-of-line word; a four-word queue lets input and output stall independently
// reset clears parser state and queues; the column map is not cleared
module vcf_genotype_line_parser
  import vgp_pkg::*;
#(
  parameter int MAX_COLUMNS = 4096,
  parameter int MAX_ALTS    = 8,
  parameter int NODE_BITS   = 24,
  parameter int FIRST_SAMPLE_COLUMN = 9
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic [7:0]                  text_byte_i,
  input  logic [11:0]                 map_column_i,
  input  logic signed [NODE_BITS:0]   map_node_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  kind_o,
  output logic [31:0]                 position_o,
  output logic [3:0]                  ref_code_o,
  output logic [NODE_BITS-1:0]        node_index_o,
  output logic [3:0]                  allele_code_o,
  output logic                        last_o
);

  localparam int CW = $clog2(MAX_COLUMNS) + 1;
  localparam int QW = $bits(ctl_t) + CW + NODE_BITS + 1 + 4 + 32 + 4;

  logic               push, pop, empty, full;
  ctl_t               f_ctl, b_ctl;
  logic [CW-1:0]      f_col, b_col;
  logic [NODE_BITS:0] f_node, b_node;
  logic [3:0]         f_allele, b_allele, f_ref, b_ref;
  logic [31:0]        f_pos, b_pos;
  logic [QW-1:0]      q_wdata, q_rdata;

  assign in_stall_o = full;

  vgp_front #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ALTS(MAX_ALTS),
    .NODE_BITS(NODE_BITS),
    .FIRST_SAMPLE_COLUMN(FIRST_SAMPLE_COLUMN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_valid_i && !full),
    .mode_i      (mode_i),
    .text_byte_i (text_byte_i),
    .map_column_i(map_column_i),
    .map_node_i  (map_node_i),
    .push_o      (push),
    .ctl_o       (f_ctl),
    .col_o       (f_col),
    .node_o      (f_node),
    .allele_o    (f_allele),
    .pos_o       (f_pos),
    .ref_o       (f_ref)
  );

  assign q_wdata = {f_ctl, f_col, f_node, f_allele, f_pos, f_ref};
  assign {b_ctl, b_col, b_node, b_allele, b_pos, b_ref} = q_rdata;

  vgp_fifo #(
    .WIDTH(QW),
    .DEPTH(4)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(q_wdata),
    .pop_i  (pop),
    .rdata_o(q_rdata),
    .empty_o(empty),
    .full_o (full)
  );

  vgp_back #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .NODE_BITS(NODE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .pop_o        (pop),
    .ctl_i        (b_ctl),
    .col_i        (b_col),
    .node_i       (b_node),
    .allele_i     (b_allele),
    .pos_i        (b_pos),
    .ref_i        (b_ref),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .position_o   (position_o),
    .ref_code_o   (ref_code_o),
    .node_index_o (node_index_o),
    .allele_code_o(allele_code_o),
    .last_o       (last_o)
  );

endmodule

/* sim/vcf_genotype_line_parser_test.sv */
`timescale 1ns / 100ps

module vcf_genotype_line_parser_test
  import vgp_pkg::*;
;

  localparam int MAP_DEPTH = 4096;
  localparam int ALT_DEPTH = 8;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    logic               mode;
    logic [7:0]         text;
    logic [11:0]        column;
    logic signed [24:0] node;
    bit                 hold;
  } word_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] position;
    logic [3:0]  ref_code;
    logic [23:0] node_index;
    logic [3:0]  allele_code;
    logic        last;
  } result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               mode_i;
  logic [7:0]         text_byte_i;
  logic [11:0]        map_column_i;
  logic signed [24:0] map_node_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         kind_o;
  logic [31:0]        position_o;
  logic [3:0]         ref_code_o;
  logic [23:0]        node_index_o;
  logic [3:0]         allele_code_o;
  logic               last_o;

  vcf_genotype_line_parser dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .mode_i(mode_i), .text_byte_i(text_byte_i),
    .map_column_i(map_column_i), .map_node_i(map_node_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .kind_o(kind_o), .position_o(position_o), .ref_code_o(ref_code_o),
    .node_index_o(node_index_o), .allele_code_o(allele_code_o), .last_o(last_o)
  );

  word_t   pending_words[$];
  result_t expected_results[$];
  word_t   cur_word;
  int      cycle_count;
  int      words_accepted;
  int      results_seen;
  int      line_count;
  int      mutation_count;
  int      mismatch_count;

  // parser shadow state
  logic [2:0]  phase;
  logic [31:0] pos_acc;
  logic [3:0]  ref_base;
  logic [3:0]  alt_bases[ALT_DEPTH];
  int          alt_n;
  int          skip_n;
  logic [15:0] gt_acc;
  logic [1:0]  gt_state;
  int          col_n;
  logic [24:0] column_nodes[MAP_DEPTH];

  initial clk_i = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [3:0] base_code(logic [7:0] c);
    logic [7:0] lc;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    case (lc)
      "a": return 4'h1;
      "c": return 4'h2;
      "g": return 4'h4;
      "t": return 4'h8;
      "r": return 4'h5;
      "y": return 4'ha;
      "s": return 4'h6;
      "w": return 4'h9;
      "k": return 4'hc;
      "m": return 4'h3;
      "b": return 4'he;
      "d": return 4'hd;
      "h": return 4'hb;
      "v": return 4'h7;
      default: return UNKNOWN_CODE;
    endcase
  endfunction

  function automatic bit idle_now();
    if (cycle_count >= 3000 && cycle_count < 5000) return 1'b0;
    return $urandom_range(99) < 19;
  endfunction

  function automatic result_t make_result(logic [1:0] kind, logic [23:0] node,
                                          logic [3:0] allele);
    result_t r;
    r.kind = kind;
    r.position = pos_acc;
    r.ref_code = ref_base;
    r.node_index = node;
    r.allele_code = allele;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic close_sample(inout result_t outs[$]);
    logic [24:0] v;
    logic [31:0] g;
    if (col_n < MAP_DEPTH) begin
      v = column_nodes[col_n];
      if (!v[24] && v != 0) begin
        g = (gt_state == GS_AWAIT) ? 32'hffff : 32'(gt_acc);
        if (g >= alt_n + 1) begin
          outs = {outs, make_result(KIND_SAMPLE, v[23:0], UNKNOWN_CODE)};
          mutation_count++;
        end else if (g != 0) begin
          outs = {outs, make_result(KIND_SAMPLE, v[23:0], alt_bases[g - 1])};
          mutation_count++;
        end
      end
      col_n++;
    end
    gt_acc = '0;
    gt_state = GS_AWAIT;
  endtask

  task automatic start_line();
    phase = PH_CHROM;
    pos_acc = '0;
    ref_base = '0;
    alt_n = 0;
    skip_n = 0;
    gt_acc = '0;
    gt_state = GS_AWAIT;
    col_n = 9;
  endtask

  task automatic predict_word(word_t w);
    result_t outs[$];
    logic [7:0] c;
    bit digit;
    logic [35:0] p;
    logic [31:0] g;
    c = w.text;
    digit = c >= CH_ZERO && c <= CH_NINE;
    if (w.mode) begin
      column_nodes[w.column] = w.node;
      return;
    end
    if (c == CH_NL) begin
      if (phase == PH_SAMPLE) close_sample(outs);
      outs = {outs, make_result(KIND_EOL, '0, '0)};
      start_line();
      line_count++;
    end else begin
      case (phase)
        PH_CHROM: if (c == CH_TAB) phase = PH_POS;
        PH_POS: begin
          if (c == CH_TAB) phase = PH_ID;
          else if (digit) begin
            p = 36'(pos_acc) * 10 + 36'(c - CH_ZERO);
            pos_acc = (p > 36'hffffffff) ? 32'hffffffff : p[31:0];
          end
        end
        PH_ID: if (c == CH_TAB) begin
          phase = PH_REF_FIRST;
          ref_base = UNKNOWN_CODE;
        end
        PH_REF_FIRST, PH_REF_REST: begin
          if (c == CH_TAB) begin
            outs = {outs, make_result((pos_acc == 0) ? KIND_BADPOS : KIND_LOCUS, '0, '0)};
            phase = PH_ALT;
            alt_n = 0;
          end else if (phase == PH_REF_FIRST) begin
            ref_base = base_code(c);
            phase = PH_REF_REST;
          end
        end
        PH_ALT: begin
          if (c == CH_TAB) begin
            phase = PH_SKIP;
            skip_n = 0;
          end else if (c != CH_COMMA && alt_n < ALT_DEPTH) begin
            alt_bases[alt_n] = base_code(c);
            alt_n++;
          end
        end
        PH_SKIP: if (c == CH_TAB) begin
          skip_n++;
          if (skip_n >= SKIP_FIELDS) begin
            phase = PH_SAMPLE;
            col_n = 9;
            gt_acc = '0;
            gt_state = GS_AWAIT;
          end
        end
        default: begin
          if (c == CH_TAB) close_sample(outs);
          else if (gt_state == GS_AWAIT) begin
            if (digit) begin
              gt_acc = 16'(c - CH_ZERO);
              gt_state = GS_DIGITS;
            end else begin
              gt_acc = GT_SAT;
              gt_state = GS_SKIP;
            end
          end else if (gt_state == GS_DIGITS) begin
            if (digit) begin
              g = 32'(gt_acc) * 10 + 32'(c - CH_ZERO);
              gt_acc = (g > 32'hffff) ? GT_SAT : g[15:0];
            end else gt_state = GS_SKIP;
          end
        end
      endcase
    end
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
    foreach (outs[i]) expected_results = {expected_results, outs[i]};
  endtask

  task automatic add_byte(logic [7:0] b);
    word_t w;
    w.mode = 1'b0;
    w.text = b;
    w.column = 12'($urandom);
    w.node = 25'($urandom);
    w.hold = 1'b0;
    pending_words = {pending_words, w};
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_load(logic [11:0] column, logic signed [24:0] node);
    word_t w;
    w.mode = 1'b1;
    w.text = 8'($urandom);
    w.column = column;
    w.node = node;
    w.hold = 1'b0;
    pending_words = {pending_words, w};
  endtask

  function automatic logic signed [24:0] random_node();
    case ($urandom_range(5))
      0: return 25'sd0;
      1: return -25'sd1;
      2: return 25'sd16777215;
      default: return 25'($urandom_range(16777215, 1));
    endcase
  endfunction

  function automatic logic [7:0] random_base();
    string letters;
    letters = "ACGTRYSWKMBDHVacgtrysNn.*x";
    return letters[$urandom_range(letters.len() - 1)];
  endfunction

  task automatic add_genotype();
    case ($urandom_range(7))
      0: add_text("0");
      1: add_text("1");
      2: begin
        add_byte(8'(CH_ZERO + $urandom_range(9)));
        add_text("|");
        add_byte(8'(CH_ZERO + $urandom_range(9)));
      end
      3: add_text("./.");
      4: ;
      5: add_text($sformatf("%0d", $urandom_range(99999)));
      6: add_text($sformatf("%0d:35", $urandom_range(3)));
      default: add_byte(8'(CH_ZERO + $urandom_range(2)));
    endcase
  endtask

  // well-formed line with random content, cut short now and then
  task automatic add_random_line();
    int cut;
    int n;
    cut = ($urandom_range(9) == 0) ? $urandom_range(8) : 99;
    add_text($sformatf("chr%0d", $urandom_range(22)));
    add_byte(CH_TAB);
    case ($urandom_range(5))
      0: add_text("0");
      1: add_text("98765432101");
      2: add_text($sformatf("1%0dx2", $urandom_range(999)));
      default: add_text($sformatf("%0d", $urandom_range(100000000, 1)));
    endcase
    if (cut == 0) begin add_byte(CH_NL); return; end
    add_byte(CH_TAB);
    add_text(".");
    add_byte(CH_TAB);
    n = $urandom_range(2);
    if ($urandom_range(9) == 0) n = 0;
    for (int i = 0; i < n + 1; i++) if (i < n || n == 0) add_byte(random_base());
    if (cut == 1) begin add_byte(CH_NL); return; end
    add_byte(CH_TAB);
    n = ($urandom_range(7) == 0) ? $urandom_range(11, 9) : $urandom_range(4, 1);
    for (int i = 0; i < n; i++) begin
      if (i > 0) add_byte(CH_COMMA);
      add_byte(random_base());
    end
    if (cut == 2) begin add_byte(CH_NL); return; end
    add_byte(CH_TAB);
    add_text("50\tPASS\t.\tGT");
    n = $urandom_range(12);
    for (int i = 0; i < n; i++) begin
      add_byte(CH_TAB);
      add_genotype();
      if (cut >= 3 && cut <= 8 && i == cut) begin add_byte(CH_NL); return; end
    end
    add_byte(CH_NL);
  endtask

  task automatic add_noise();
    int n;
    n = $urandom_range(30, 1);
    for (int i = 0; i < n; i++)
      add_byte(($urandom_range(4) == 0) ? CH_TAB : 8'($urandom));
    add_byte(CH_NL);
  endtask

  // stimulus
  initial begin
    rst_ni = 1'b0;
    start_line();
    for (int i = 0; i < 128; i++) add_load(12'(i), random_node());
    add_load(12'd10, 25'sd16777215);
    add_load(12'd11, -25'sd1);
    add_load(12'd12, 25'sd0);
    add_load(12'd4095, 25'sd5);
    add_text("1\t0\t.\tA\tC\t.\t.\t.\tGT\t1\t1\t1\t1\n");
    add_text("c\t99999999999\t.\t\tG,T,A,C,G,T,A,C,G,T\t.\t.\t.\tGT\t10\t9\t.\t\t99999\n");
    add_text("\n");
    add_text("c\t7\t.\tgtx\tN\t.\t.\t.\t.\t0\t1");
    add_text("\n");
    add_text("c\t12\n");
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_words.size() > 0) @(posedge clk_i);
    while (words_accepted < 128 + 4) @(posedge clk_i);
    begin
      int first;
      first = pending_words.size();
      while (pending_words.size() + words_accepted < 1150) begin
        case ($urandom_range(19))
          0, 1: add_noise();
          2: add_load(12'($urandom), random_node());
          3: add_load(12'($urandom_range(127)), random_node());
          default: add_random_line();
        endcase
      end
      pending_words[first].hold = 1'b1;
    end
    while (pending_words.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("%0d words accepted, %0d lines, %0d results checked (%0d mutations)",
             words_accepted, line_count, results_seen, mutation_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Verification failed");
    end
    $finish;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      mode_i <= 1'b0;
      text_byte_i <= '0;
      map_column_i <= '0;
      map_node_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_word(cur_word);
        words_accepted++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (pending_words.size() > 0 && !idle_now() &&
            (!pending_words[0].hold || expected_results.size() == 0)) begin
          cur_word = pending_words.pop_front();
          in_valid_i <= 1'b1;
          mode_i <= cur_word.mode;
          text_byte_i <= cur_word.text;
          map_column_i <= cur_word.column;
          map_node_i <= cur_word.node;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected word: kind %0d position %0d", kind_o, position_o);
        end else begin
          e = expected_results.pop_front();
          if (kind_o !== e.kind || position_o !== e.position || ref_code_o !== e.ref_code ||
              node_index_o !== e.node_index || allele_code_o !== e.allele_code ||
              last_o !== e.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %0d %0d %h %0d %h %b, got %0d %0d %h %0d %h %b",
                       e.kind, e.position, e.ref_code, e.node_index, e.allele_code,
                       e.last, kind_o, position_o, ref_code_o, node_index_o,
                       allele_code_o, last_o);
          end
        end
      end
      out_stall_i <= idle_now();
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
